// ----- rtl/core/bnc_pkg.sv -----
// Shared types, constants and byte decode for the bracket nesting checker.
// No dependencies; every other file in rtl/core uses this package.
package bnc_pkg;

    localparam int STACK_DEPTH_DEF = 128;

    localparam int KIND_W   = 2;
    localparam int WEIGHT_W = 16;
    localparam int SCORE_W  = 64;
    localparam int CFG_IDX_W = 8;

    localparam logic [7:0] NL_BYTE = 8'd10;

    localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CURLY  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ROUND  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SQUARE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CURLY  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ANGLE  = 8'd3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ROUND_RST  = 16'd3;
    localparam logic [WEIGHT_W-1:0] WEIGHT_SQUARE_RST = 16'd57;
    localparam logic [WEIGHT_W-1:0] WEIGHT_CURLY_RST  = 16'd1197;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ANGLE_RST  = 16'd25137;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [KIND_W-1:0] kind;
    } stack_cmd_t;

    typedef struct packed {
        logic              is_open;
        logic              is_close;
        logic              is_nl;
        logic [KIND_W-1:0] kind;
    } char_class_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r = '0;
        unique case (c)
            8'h28: begin r.is_open  = 1'b1; r.kind = KIND_ROUND;  end
            8'h5B: begin r.is_open  = 1'b1; r.kind = KIND_SQUARE; end
            8'h7B: begin r.is_open  = 1'b1; r.kind = KIND_CURLY;  end
            8'h3C: begin r.is_open  = 1'b1; r.kind = KIND_ANGLE;  end
            8'h29: begin r.is_close = 1'b1; r.kind = KIND_ROUND;  end
            8'h5D: begin r.is_close = 1'b1; r.kind = KIND_SQUARE; end
            8'h7D: begin r.is_close = 1'b1; r.kind = KIND_CURLY;  end
            8'h3E: begin r.is_close = 1'b1; r.kind = KIND_ANGLE;  end
            NL_BYTE: r.is_nl = 1'b1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/bracket_nesting_checker_core.sv -----
// Top level of the bracket nesting checker: byte decode, line state, score unit.
// Depends on bnc_pkg and bnc_stack.
//
// Takes one text byte per request and checks bracket nesting line by line; a newline
// produces one result. Other bytes are taken without a stall: openers shift
// into a row of STACK_DEPTH cells and closers compare against and shift out of cell 0.
// A newline stalls the input while the open brackets of a clean line (none for a corrupt
// line) are walked: the completion score pops one cell per cycle
// through a single 64-bit multiply-by-five-and-add unit, then the result is loaded into
// the output register. Further bytes are taken while that result waits to be collected;
// the load of the next line's result, and with it the input, waits until the output
// register is free.
module bracket_nesting_checker_core
#(
    parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bnc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bnc_pkg::WEIGHT_W-1:0]       cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         char_in,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               line_corrupt,
    output logic [bnc_pkg::WEIGHT_W-1:0]       line_error_score,
    output logic [bnc_pkg::SCORE_W-1:0]        completion_score,
    output logic [bnc_pkg::SCORE_W-1:0]        error_total,
    output logic                               depth_overflow
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(STACK_DEPTH);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                          state_reg, state_next;
    logic [DEPTH_W-1:0]            depth_reg, depth_next;
    logic                          bad_reg, bad_next;
    logic [bnc_pkg::WEIGHT_W-1:0]  pen_reg, pen_next;
    logic                          ovf_reg, ovf_next;
    logic [bnc_pkg::SCORE_W-1:0]   total_reg, total_next;

    logic                          pend_bad_reg, pend_bad_next;
    logic [bnc_pkg::WEIGHT_W-1:0]  pend_pen_reg, pend_pen_next;
    logic                          pend_ovf_reg, pend_ovf_next;
    logic [bnc_pkg::SCORE_W-1:0]   score_reg, score_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          out_corrupt_reg;
    logic [bnc_pkg::WEIGHT_W-1:0]  out_pen_reg;
    logic [bnc_pkg::SCORE_W-1:0]   out_score_reg;
    logic [bnc_pkg::SCORE_W-1:0]   out_total_reg;
    logic                          out_ovf_reg;

    logic [bnc_pkg::WEIGHT_W-1:0]  w_round_reg, w_square_reg, w_curly_reg, w_angle_reg;
    logic [bnc_pkg::WEIGHT_W-1:0]  weight_sel;

    bnc_pkg::char_class_t          cls;
    bnc_pkg::stack_cmd_t           cmd;
    logic [bnc_pkg::KIND_W-1:0]    top_kind;
    logic                          in_fire;
    logic                          out_load;
    logic                          match;

    bnc_stack
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_stack
    (
        .clk      (clk),
        .cmd      (cmd),
        .top_kind (top_kind)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg == ST_WALK);
    assign in_fire   = in_valid && !in_stall;
    assign cls       = bnc_pkg::classify(char_in);
    assign match     = (depth_reg != '0) && (top_kind == cls.kind);
    assign out_load  = (state_reg == ST_WALK) && (depth_reg == '0)
                       && (!out_valid_reg || !out_stall);

    always_comb
    begin
        unique case (cls.kind)
            bnc_pkg::KIND_ROUND:  weight_sel = w_round_reg;
            bnc_pkg::KIND_SQUARE: weight_sel = w_square_reg;
            bnc_pkg::KIND_CURLY:  weight_sel = w_curly_reg;
            bnc_pkg::KIND_ANGLE:  weight_sel = w_angle_reg;
            default:              weight_sel = w_angle_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        bad_next       = bad_reg;
        pen_next       = pen_reg;
        ovf_next       = ovf_reg;
        total_next     = total_reg;
        pend_bad_next  = pend_bad_reg;
        pend_pen_next  = pend_pen_reg;
        pend_ovf_next  = pend_ovf_reg;
        score_next     = score_reg;
        cmd            = '0;
        cmd.kind       = cls.kind;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_RUN:
            begin
                if (in_fire)
                begin
                    priority if (cls.is_nl)
                    begin
                        pend_bad_next = bad_reg;
                        pend_pen_next = bad_reg ? pen_reg : '0;
                        pend_ovf_next = ovf_reg;
                        score_next    = '0;
                        bad_next      = 1'b0;
                        pen_next      = '0;
                        ovf_next      = 1'b0;
                        if (bad_reg)
                        begin
                            depth_next = '0;
                        end
                        state_next = ST_WALK;
                    end
                    else if (bad_reg)
                    begin
                        // drop the rest of a corrupt line
                    end
                    else if (cls.is_open)
                    begin
                        if (depth_reg < DEPTH_MAX)
                        begin
                            cmd.push   = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (cls.is_close)
                    begin
                        if (match)
                        begin
                            cmd.pop    = 1'b1;
                            depth_next = depth_reg - DEPTH_W'(1);
                        end
                        else
                        begin
                            bad_next   = 1'b1;
                            pen_next   = weight_sel;
                            total_next = total_reg + bnc_pkg::SCORE_W'(weight_sel);
                        end
                    end
                    else
                    begin
                        // drop any other byte
                    end
                end
            end
            ST_WALK:
            begin
                if (depth_reg != '0)
                begin
                    cmd.pop    = 1'b1;
                    depth_next = depth_reg - DEPTH_W'(1);
                    score_next = (score_reg << 2) + score_reg
                                 + bnc_pkg::SCORE_W'(top_kind) + bnc_pkg::SCORE_W'(1);
                end
                else if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            depth_reg     <= '0;
            bad_reg       <= 1'b0;
            pen_reg       <= '0;
            ovf_reg       <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            w_round_reg   <= bnc_pkg::WEIGHT_ROUND_RST;
            w_square_reg  <= bnc_pkg::WEIGHT_SQUARE_RST;
            w_curly_reg   <= bnc_pkg::WEIGHT_CURLY_RST;
            w_angle_reg   <= bnc_pkg::WEIGHT_ANGLE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            bad_reg       <= bad_next;
            pen_reg       <= pen_next;
            ovf_reg       <= ovf_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bnc_pkg::REG_WEIGHT_ROUND:  w_round_reg  <= cfg_data;
                    bnc_pkg::REG_WEIGHT_SQUARE: w_square_reg <= cfg_data;
                    bnc_pkg::REG_WEIGHT_CURLY:  w_curly_reg  <= cfg_data;
                    bnc_pkg::REG_WEIGHT_ANGLE:  w_angle_reg  <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_bad_reg <= pend_bad_next;
        pend_pen_reg <= pend_pen_next;
        pend_ovf_reg <= pend_ovf_next;
        score_reg    <= score_next;
        if (out_load)
        begin
            out_corrupt_reg <= pend_bad_reg;
            out_pen_reg     <= pend_pen_reg;
            out_score_reg   <= score_reg;
            out_total_reg   <= total_reg;
            out_ovf_reg     <= pend_ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign line_corrupt     = out_corrupt_reg;
    assign line_error_score = out_pen_reg;
    assign completion_score = out_score_reg;
    assign error_total      = out_total_reg;
    assign depth_overflow   = out_ovf_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_MAX)
        else $error("stack depth beyond capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> depth_reg != '0)
        else $error("pop on empty stack");

    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WALK))
        else $error("result raised outside the score walk");

    a_corrupt_no_score: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_corrupt_reg |-> out_score_reg == '0)
        else $error("corrupt line carries a completion score");

    a_clean_no_penalty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_corrupt_reg |-> out_pen_reg == '0)
        else $error("clean line carries an error score");
`endif

endmodule

// ----- rtl/core/bnc_cell.sv -----
// One stack cell: holds a 2-bit opener kind, shifts down on push, up on pop.
// Depends on bnc_pkg.
module bnc_cell
(
    input  logic                              clk,
    input  bnc_pkg::stack_cmd_t               cmd,
    input  logic [bnc_pkg::KIND_W-1:0]        from_above,
    input  logic [bnc_pkg::KIND_W-1:0]        from_below,
    output logic [bnc_pkg::KIND_W-1:0]        kind
);

    logic [bnc_pkg::KIND_W-1:0] kind_reg;
    logic [bnc_pkg::KIND_W-1:0] kind_next;

    always_comb
    begin
        kind_next = kind_reg;
        priority if (cmd.push)
        begin
            kind_next = from_above;
        end
        else if (cmd.pop)
        begin
            kind_next = from_below;
        end
        else
        begin
            kind_next = kind_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule

// ----- rtl/core/bnc_stack.sv -----
// Opener stack built as a row of shifting cells; cell 0 is the top of stack.
// Depends on bnc_pkg and bnc_cell.
module bnc_stack
#(
    parameter int STACK_DEPTH = bnc_pkg::STACK_DEPTH_DEF
)
(
    input  logic                              clk,
    input  bnc_pkg::stack_cmd_t               cmd,
    output logic [bnc_pkg::KIND_W-1:0]        top_kind
);

    logic [bnc_pkg::KIND_W-1:0] kinds [STACK_DEPTH];

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [bnc_pkg::KIND_W-1:0] above;
        logic [bnc_pkg::KIND_W-1:0] below;

        if (i == 0)
        begin : g_top
            assign above = cmd.kind;
        end
        else
        begin : g_mid
            assign above = kinds[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign below = kinds[i];
        end
        else
        begin : g_inner
            assign below = kinds[i+1];
        end

        bnc_cell u_cell
        (
            .clk        (clk),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .kind       (kinds[i])
        );
    end

    assign top_kind = kinds[0];

endmodule
